@@ rtl/core/wrs_pkg.sv @@
`default_nettype none
package wrs_pkg;

    localparam int SAMPLE_W = 20;
    localparam int COUNT_W  = 20;
    localparam int SUM_W    = 40;
    localparam int SQSUM_W  = 60;
    localparam int PROD_W   = 80;
    localparam int DVD_W    = 96;
    localparam int DVS_W    = 40;
    localparam int QUO_W    = 64;
    localparam int ROOT_W   = 32;
    localparam int STAT_W   = 28;
    localparam int STEP_W   = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 20'hFFFFF;

    localparam logic [1:0] MODE_ADD     = 2'd0;
    localparam logic [1:0] MODE_CLR_WIN = 2'd1;
    localparam logic [1:0] MODE_CLR_RPT = 2'd2;

    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] n;
        logic [SUM_W-1:0]   s;
        logic [SQSUM_W-1:0] sq;
    } stat_req_t;

    typedef struct packed {
        logic              busy;
        logic [STAT_W-1:0] mean;
        logic [STAT_W-1:0] stddev;
    } stat_rsp_t;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic [QUO_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic             start;
        logic [QUO_W-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic              busy;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

endpackage
`default_nettype wire

@@ rtl/core/windowed_and_running_stats.sv @@
`default_nettype none
// Per-channel timing statistics. Each request either adds a sample (mode 0), clears
// all windows and the shared cursor (mode 1), or clears all report accumulators
// (mode 2), and always yields one result: window mean/stddev, report mean/stddev
// and report count for the named channel, Q20.8 truncated. A request is not taken
// until the result of the one before it has moved into the output register. The
// two statistics engines (one for the window, one for the report) run side by side
// and set the time an add request takes: mean divide, shift-add products, subtract
// and handoff, variance divide and square root, all bit-serial, plus sequencing.
// With fewer than two samples in both sets the engines finish early. The window
// store is a CHANNELS x WINDOW memory (rounded up to powers of two, 512 words at
// defaults) with a valid bit per word; after reset and after each mode 1 request a
// clearing pass walks it, one word per cycle, before requests resume.
// Config writes are taken at any time but only meant while idle.
module windowed_and_running_stats
    import wrs_pkg::*;
#(
    parameter int WINDOW   = 128,
    parameter int CHANNELS = 4
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // config
    input  wire logic                cfg_wr_en,
    input  wire logic [2:0]          cfg_wr_data,
    // request channel
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_mode,
    input  wire logic [1:0]          s_channel,
    input  wire logic [SAMPLE_W-1:0] s_sample,
    input  wire logic                s_include_in_report,
    input  wire logic                s_end_of_frame,
    // result channel
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [1:0]               m_result_channel,
    output logic [STAT_W-1:0]        m_window_mean,
    output logic [STAT_W-1:0]        m_window_stddev,
    output logic [STAT_W-1:0]        m_report_mean,
    output logic [STAT_W-1:0]        m_report_stddev,
    output logic [COUNT_W-1:0]       m_report_count
);

    localparam int CW     = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int WS_W   = SAMPLE_W + FILL_W;
    localparam int WQ_W   = 2 * SAMPLE_W + FILL_W;
    localparam int SQ_W   = 2 * SAMPLE_W;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW     = CH_W + CW;
    localparam int DEPTH  = 1 << AW;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_SQUARE = 3'd3;
    localparam logic [2:0] ST_UPDATE = 3'd4;
    localparam logic [2:0] ST_START  = 3'd5;
    localparam logic [2:0] ST_WAIT   = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    localparam logic [2:0] ACT_RESET = 3'd4;

    logic [2:0]          state_reg;
    logic [AW-1:0]       clr_addr_reg;
    logic                pend_reg;
    logic [2:0]          act_reg;
    logic [CW-1:0]       cursor_reg;

    logic [1:0]          ch_reg;
    logic [SAMPLE_W-1:0] x_reg;
    logic                inc_reg;
    logic                eof_reg;

    logic [FILL_W-1:0]   fill_reg [CHANNELS];
    logic [WS_W-1:0]     wsum_reg [CHANNELS];
    logic [WQ_W-1:0]     wsq_reg  [CHANNELS];
    logic [SUM_W-1:0]    rtot_reg [CHANNELS];
    logic [SQSUM_W-1:0]  rsq_reg  [CHANNELS];
    logic [COUNT_W-1:0]  rcnt_reg [CHANNELS];

    // word = {valid, sample}
    logic [SAMPLE_W:0]   window_store_mem [DEPTH];
    logic [SAMPLE_W:0]   rd_data_reg;
    logic [SQ_W-1:0]     old_sq_reg;
    logic [SQ_W-1:0]     x_sq_reg;

    logic                m_valid_reg;
    logic [1:0]          res_ch_reg;
    logic [STAT_W-1:0]   res_wmean_reg;
    logic [STAT_W-1:0]   res_wsd_reg;
    logic [STAT_W-1:0]   res_rmean_reg;
    logic [STAT_W-1:0]   res_rsd_reg;
    logic [COUNT_W-1:0]  res_rcnt_reg;

    logic                s_fire;
    logic                s_ch_active;
    logic                ch_in_range;
    logic [CH_W-1:0]     ch_idx;
    logic [AW-1:0]       slot_addr;
    logic [CW-1:0]       cursor_inc;
    logic                out_free;
    logic                old_valid;
    logic [SAMPLE_W-1:0] old_x;

    logic                mem_we;
    logic [AW-1:0]       mem_addr;
    logic [SAMPLE_W:0]   mem_wdata;

    stat_req_t           win_req;
    stat_req_t           rpt_req;
    stat_rsp_t           win_rsp;
    stat_rsp_t           rpt_rsp;

    assign s_ready     = state_reg == ST_IDLE;
    assign s_fire      = s_valid && s_ready;
    // channel must be below both the configured limit and the build limit
    assign s_ch_active = ({1'b0, s_channel} < act_reg) && (32'(s_channel) < CHANNELS);
    assign ch_in_range = 32'(ch_reg) < CHANNELS;
    assign ch_idx      = CH_W'(ch_reg);
    assign slot_addr   = {ch_idx, cursor_reg};
    assign cursor_inc  = (32'(cursor_reg) == WINDOW - 1) ? '0 : cursor_reg + CW'(1);
    assign out_free    = !m_valid_reg || m_ready;
    assign old_valid   = rd_data_reg[SAMPLE_W];
    assign old_x       = rd_data_reg[SAMPLE_W-1:0];

    // Window store: clearing pass writes invalid words, an add writes {1, x}.
    assign mem_we    = state_reg == ST_CLEAR || state_reg == ST_UPDATE;
    assign mem_addr  = (state_reg == ST_CLEAR) ? clr_addr_reg : slot_addr;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : {1'b1, x_reg};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            window_store_mem[mem_addr] <= mem_wdata;
        end
        if (state_reg == ST_READ) begin
            rd_data_reg <= window_store_mem[slot_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= ACT_RESET;
        end else if (cfg_wr_en) begin
            act_reg <= cfg_wr_data;
        end
    end

    // Engines get the named channel's state after this request's update.
    always_comb begin
        win_req.start = state_reg == ST_START && ch_in_range;
        win_req.n     = COUNT_W'(fill_reg[ch_idx]);
        win_req.s     = SUM_W'(wsum_reg[ch_idx]);
        win_req.sq    = SQSUM_W'(wsq_reg[ch_idx]);
        rpt_req.start = win_req.start;
        rpt_req.n     = rcnt_reg[ch_idx];
        rpt_req.s     = rtot_reg[ch_idx];
        rpt_req.sq    = rsq_reg[ch_idx];
    end

    wrs_stat u_win_stat (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (win_req),
        .rsp     (win_rsp)
    );

    wrs_stat u_rpt_stat (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rpt_req),
        .rsp     (rpt_rsp)
    );

    // Main sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
            cursor_reg   <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                fill_reg[i] <= '0;
                wsum_reg[i] <= '0;
                wsq_reg[i]  <= '0;
                rtot_reg[i] <= '0;
                rsq_reg[i]  <= '0;
                rcnt_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (32'(clr_addr_reg) == DEPTH - 1) begin
                        pend_reg  <= 1'b0;
                        state_reg <= pend_reg ? ST_START : ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_fire) begin
                        ch_reg   <= s_channel;
                        x_reg    <= s_sample;
                        inc_reg  <= s_include_in_report;
                        eof_reg  <= s_end_of_frame;
                        case (s_mode)
                            MODE_ADD: begin
                                if (s_ch_active) begin
                                    state_reg <= ST_READ;
                                end else begin
                                    // inactive channel only moves the cursor, and only at end of frame
                                    if (s_end_of_frame) begin
                                        cursor_reg <= cursor_inc;
                                    end
                                    state_reg <= ST_START;
                                end
                            end
                            MODE_CLR_WIN: begin
                                for (int i = 0; i < CHANNELS; i++) begin
                                    fill_reg[i] <= '0;
                                    wsum_reg[i] <= '0;
                                    wsq_reg[i]  <= '0;
                                end
                                cursor_reg   <= '0;
                                clr_addr_reg <= '0;
                                pend_reg     <= 1'b1;
                                state_reg    <= ST_CLEAR;
                            end
                            MODE_CLR_RPT: begin
                                for (int i = 0; i < CHANNELS; i++) begin
                                    rtot_reg[i] <= '0;
                                    rsq_reg[i]  <= '0;
                                    rcnt_reg[i] <= '0;
                                end
                                state_reg <= ST_START;
                            end
                            default: begin
                                state_reg <= ST_START;
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    state_reg <= ST_SQUARE;
                end
                ST_SQUARE: begin
                    old_sq_reg <= old_x * old_x;
                    x_sq_reg   <= x_reg * x_reg;
                    state_reg  <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    // overwriting a valid slot swaps the old value out of the sums
                    if (old_valid) begin
                        wsum_reg[ch_idx] <= wsum_reg[ch_idx] - WS_W'(old_x) + WS_W'(x_reg);
                        wsq_reg[ch_idx]  <= wsq_reg[ch_idx] - WQ_W'(old_sq_reg)
                                          + WQ_W'(x_sq_reg);
                    end else begin
                        wsum_reg[ch_idx] <= wsum_reg[ch_idx] + WS_W'(x_reg);
                        wsq_reg[ch_idx]  <= wsq_reg[ch_idx] + WQ_W'(x_sq_reg);
                        fill_reg[ch_idx] <= fill_reg[ch_idx] + FILL_W'(1);
                    end
                    // report accumulator stops at full count
                    if (inc_reg && rcnt_reg[ch_idx] != COUNT_MAX) begin
                        rcnt_reg[ch_idx] <= rcnt_reg[ch_idx] + COUNT_W'(1);
                        rtot_reg[ch_idx] <= rtot_reg[ch_idx] + SUM_W'(x_reg);
                        rsq_reg[ch_idx]  <= rsq_reg[ch_idx] + SQSUM_W'(x_sq_reg);
                    end
                    if (eof_reg) begin
                        cursor_reg <= cursor_inc;
                    end
                    state_reg <= ST_START;
                end
                ST_START: begin
                    state_reg <= ch_in_range ? ST_WAIT : ST_OUT;
                end
                ST_WAIT: begin
                    if (!win_rsp.busy && !rpt_rsp.busy) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Output register: holds a result while the next request is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            res_ch_reg <= ch_reg;
            if (ch_in_range) begin
                res_wmean_reg <= win_rsp.mean;
                res_wsd_reg   <= win_rsp.stddev;
                res_rmean_reg <= rpt_rsp.mean;
                res_rsd_reg   <= rpt_rsp.stddev;
                res_rcnt_reg  <= rcnt_reg[ch_idx];
            end else begin
                res_wmean_reg <= '0;
                res_wsd_reg   <= '0;
                res_rmean_reg <= '0;
                res_rsd_reg   <= '0;
                res_rcnt_reg  <= '0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_result_channel = res_ch_reg;
    assign m_window_mean    = res_wmean_reg;
    assign m_window_stddev  = res_wsd_reg;
    assign m_report_mean    = res_rmean_reg;
    assign m_report_stddev  = res_rsd_reg;
    assign m_report_count   = res_rcnt_reg;

endmodule
`default_nettype wire

@@ rtl/core/wrs_div.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle, dividend consumed MSB first.
module wrs_div
    import wrs_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  div_req_t  req,
    output div_rsp_t  rsp
);

    logic              busy_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  quo_reg;

    logic [DVS_W:0] trial;
    logic           fits;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && cnt_reg == STEP_W'(1)) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            cnt_reg <= req.steps;
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - STEP_W'(1);
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.quot = quo_reg;

endmodule
`default_nettype wire

@@ rtl/core/wrs_sqrt.sv @@
`default_nettype none
// Digit-by-digit integer square root, two radicand bits per cycle.
module wrs_sqrt
    import wrs_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [QUO_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [REM_W-1:0] pulled;
    logic [REM_W-1:0] trial;
    logic             fits;

    assign pulled = {rem_reg[ROOT_W-1:0], rad_reg[QUO_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = pulled >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && cnt_reg == CNT_W'(1)) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            cnt_reg  <= CNT_W'(ROOT_W);
            rad_reg  <= req.radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            rad_reg  <= {rad_reg[QUO_W-3:0], 2'b00};
            rem_reg  <= fits ? pulled - trial : pulled;
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.root = root_reg;

endmodule
`default_nettype wire

@@ rtl/core/wrs_stat.sv @@
`default_nettype none
// Mean and sample stddev of (n, sum, sum of squares): serial divide for the mean,
// shift-add products for n*sq - s*s, serial divide by n*(n-1), then square root.
module wrs_stat
    import wrs_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  stat_req_t req,
    output stat_rsp_t rsp
);

    localparam logic [2:0] E_IDLE = 3'd0;
    localparam logic [2:0] E_MDIV = 3'd1;
    localparam logic [2:0] E_MUL1 = 3'd2;
    localparam logic [2:0] E_MUL2 = 3'd3;
    localparam logic [2:0] E_SUB  = 3'd4;
    localparam logic [2:0] E_DIFF = 3'd5;
    localparam logic [2:0] E_VDIV = 3'd6;
    localparam logic [2:0] E_SQRT = 3'd7;

    localparam int MCNT_W = 6;

    logic [2:0]         state_reg;
    logic [COUNT_W-1:0] n_reg;
    logic [SUM_W-1:0]   s_reg;
    logic [SQSUM_W-1:0] sq_reg;
    logic [STAT_W-1:0]  mean_reg;
    logic [STAT_W-1:0]  sd_reg;
    logic [PROD_W-1:0]  acc_reg;
    logic [PROD_W-1:0]  p1_reg;
    logic [PROD_W-1:0]  diff_reg;
    logic [SUM_W-1:0]   mul_a_reg;
    logic [SQSUM_W-1:0] mul_b_reg;
    logic [MCNT_W-1:0]  mul_cnt_reg;
    logic [DVS_W-1:0]   nn_reg;

    logic [PROD_W-1:0] acc_next;
    div_req_t          div_req;
    div_rsp_t          div_rsp;
    sqrt_req_t         sqrt_req;
    sqrt_rsp_t         sqrt_rsp;

    assign acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                    + (mul_a_reg[SUM_W-1] ? PROD_W'(mul_b_reg) : '0);

    always_comb begin
        div_req.start    = (state_reg == E_IDLE && req.start && req.n != '0)
                         || state_reg == E_DIFF;
        if (state_reg == E_IDLE) begin
            div_req.dividend = {req.s, 8'b0, 48'b0};
            div_req.divisor  = DVS_W'(req.n);
            div_req.steps    = STEP_W'(48);
        end else begin
            div_req.dividend = {diff_reg, 16'b0};
            div_req.divisor  = nn_reg;
            div_req.steps    = STEP_W'(DVD_W);
        end
    end

    assign sqrt_req.start    = state_reg == E_VDIV && !div_rsp.busy;
    assign sqrt_req.radicand = div_rsp.quot;

    wrs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    wrs_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sqrt_req),
        .rsp     (sqrt_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
        end else begin
            case (state_reg)
                E_IDLE: begin
                    if (req.start) begin
                        n_reg  <= req.n;
                        s_reg  <= req.s;
                        sq_reg <= req.sq;
                        if (req.n == '0) begin
                            mean_reg <= '0;
                            sd_reg   <= '0;
                        end else begin
                            state_reg <= E_MDIV;
                        end
                    end
                end
                E_MDIV: begin
                    if (!div_rsp.busy) begin
                        mean_reg <= div_rsp.quot[STAT_W-1:0];
                        if (n_reg < COUNT_W'(2)) begin
                            sd_reg    <= '0;
                            state_reg <= E_IDLE;
                        end else begin
                            acc_reg     <= '0;
                            mul_a_reg   <= {n_reg, 20'b0};
                            mul_b_reg   <= sq_reg;
                            mul_cnt_reg <= MCNT_W'(COUNT_W);
                            nn_reg      <= {20'b0, n_reg} * {20'b0, n_reg - COUNT_W'(1)};
                            state_reg   <= E_MUL1;
                        end
                    end
                end
                E_MUL1: begin
                    mul_a_reg   <= {mul_a_reg[SUM_W-2:0], 1'b0};
                    mul_cnt_reg <= mul_cnt_reg - MCNT_W'(1);
                    acc_reg     <= acc_next;
                    if (mul_cnt_reg == MCNT_W'(1)) begin
                        p1_reg      <= acc_next;
                        acc_reg     <= '0;
                        mul_a_reg   <= s_reg;
                        mul_b_reg   <= SQSUM_W'(s_reg);
                        mul_cnt_reg <= MCNT_W'(SUM_W);
                        state_reg   <= E_MUL2;
                    end
                end
                E_MUL2: begin
                    mul_a_reg   <= {mul_a_reg[SUM_W-2:0], 1'b0};
                    mul_cnt_reg <= mul_cnt_reg - MCNT_W'(1);
                    acc_reg     <= acc_next;
                    if (mul_cnt_reg == MCNT_W'(1)) begin
                        state_reg <= E_SUB;
                    end
                end
                E_SUB: begin
                    diff_reg  <= p1_reg - acc_reg;
                    state_reg <= E_DIFF;
                end
                E_DIFF: begin
                    state_reg <= E_VDIV;
                end
                E_VDIV: begin
                    if (!div_rsp.busy) begin
                        state_reg <= E_SQRT;
                    end
                end
                E_SQRT: begin
                    if (!sqrt_rsp.busy) begin
                        sd_reg    <= sqrt_rsp.root[STAT_W-1:0];
                        state_reg <= E_IDLE;
                    end
                end
                default: begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

    assign rsp.busy   = state_reg != E_IDLE;
    assign rsp.mean   = mean_reg;
    assign rsp.stddev = sd_reg;

endmodule
`default_nettype wire
